### rtl/pltok_pkg.sv
// Shared types, constants and helpers of the properties line tokenizer.
`default_nettype none

package pltok_pkg;

   localparam int unsigned LEN_W = 13;            // line length counter width
   localparam int unsigned MAX_LINE_DEF = 4096;   // default line length limit
   localparam int unsigned RES_MAX = 3;           // maximum results per input item
   localparam int unsigned RES_IDX_W = 2;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef enum logic [2:0] {
      MODE_START,
      MODE_COMMENT,
      MODE_BODY,
      MODE_PENDING,
      MODE_JOINSKIP,
      MODE_DROP
   } mode_type;

   typedef enum logic [1:0] {
      PH_KEY,
      PH_GAP,
      PH_VALUE,
      PH_SECTION
   } phase_type;

   typedef enum logic [1:0] {
      RK_CHAR,
      RK_EOL,
      RK_LONG,
      RK_EOI
   } rkind_type;

   typedef enum logic [1:0] {
      ROLE_KEY,
      ROLE_VALUE,
      ROLE_SECTION
   } role_type;

   typedef struct packed {
      mode_type          mode;
      logic              skip_lf;
      logic              held_bs;
      logic              eol_cr;
      logic [LEN_W-1:0]  len;
      phase_type         phase;
      logic              key_esc;
      logic              sep_found;
   } st_type;

   typedef struct packed {
      rkind_type   kind;
      logic [7:0]  chr;
      role_type    role;
      logic        sep;
      logic        last;
   } rslt_type;

   function automatic st_type clear_state();
      st_type s;
      s.mode      = MODE_START;
      s.skip_lf   = 1'b0;
      s.held_bs   = 1'b0;
      s.eol_cr    = 1'b0;
      s.len       = '0;
      s.phase     = PH_KEY;
      s.key_esc   = 1'b0;
      s.sep_found = 1'b0;
      return s;
   endfunction

endpackage

`default_nettype wire

### rtl/pltok_step.sv
// Per-item decision logic: next tokenizer state and up to three results.
`default_nettype none

module pltok_step #(
   parameter int unsigned MAX_LINE = pltok_pkg::MAX_LINE_DEF
) (
   input  var pltok_pkg::st_type                            st_i,
   input  var logic                                         kind_i,
   input  var logic [7:0]                                   byte_i,
   output pltok_pkg::st_type                                st_o,
   output pltok_pkg::rslt_type [pltok_pkg::RES_MAX-1:0]     res_o,
   output logic [pltok_pkg::RES_IDX_W-1:0]                  cnt_o
);

   typedef struct packed {
      pltok_pkg::st_type    st;
      logic                 emit;
      pltok_pkg::rslt_type  r;
   } cls_type;

   localparam logic [pltok_pkg::LEN_W-1:0] LIMIT = pltok_pkg::LEN_W'(MAX_LINE);

   function automatic logic is_blank(logic [7:0] c);
      return c == pltok_pkg::CH_SPACE || c == pltok_pkg::CH_TAB || c == pltok_pkg::CH_FF;
   endfunction

   function automatic logic is_eol(logic [7:0] c);
      return c == pltok_pkg::CH_CR || c == pltok_pkg::CH_LF;
   endfunction

   function automatic logic is_sep(logic [7:0] c);
      return c == pltok_pkg::CH_EQUALS || c == pltok_pkg::CH_COLON;
   endfunction

   // split one committed byte into key / value / section text
   function automatic cls_type classify(pltok_pkg::st_type st, logic [7:0] c);
      cls_type o;
      o.st     = st;
      o.emit   = 1'b1;
      o.r      = '0;
      o.r.kind = pltok_pkg::RK_CHAR;
      o.r.chr  = c;
      case (st.phase)
         pltok_pkg::PH_SECTION: o.r.role = pltok_pkg::ROLE_SECTION;
         pltok_pkg::PH_KEY: begin
            if (!st.key_esc && is_sep(c)) begin
               o.st.sep_found = 1'b1;
               o.st.phase     = pltok_pkg::PH_GAP;
               o.emit         = 1'b0;
            end else if (!st.key_esc && is_blank(c)) begin
               o.st.phase = pltok_pkg::PH_GAP;
               o.emit     = 1'b0;
            end else begin
               o.st.key_esc = (c == pltok_pkg::CH_BSLASH) ? ~st.key_esc : 1'b0;
               o.r.role     = pltok_pkg::ROLE_KEY;
            end
         end
         pltok_pkg::PH_GAP: begin
            if (is_blank(c)) begin
               o.emit = 1'b0;
            end else if (!st.sep_found && is_sep(c)) begin
               o.st.sep_found = 1'b1;
               o.emit         = 1'b0;
            end else begin
               o.st.phase = pltok_pkg::PH_VALUE;
               o.r.role   = pltok_pkg::ROLE_VALUE;
            end
         end
         default: o.r.role = pltok_pkg::ROLE_VALUE;
      endcase
      return o;
   endfunction

   always_comb begin
      pltok_pkg::st_type                         s;
      pltok_pkg::rslt_type [pltok_pkg::RES_MAX-1:0] res;
      logic [pltok_pkg::RES_IDX_W-1:0]           n;
      cls_type                                   cr;
      logic                                      body;
      logic                                      app;
      logic                                      stop;

      s    = st_i;
      res  = '0;
      n    = '0;
      cr   = '0;
      body = 1'b0;
      app  = 1'b0;
      stop = 1'b0;

      if (kind_i) begin
         // end of file: close a pending line (a held backslash is kept), then mark end of input
         if ((s.mode == pltok_pkg::MODE_BODY || s.mode == pltok_pkg::MODE_PENDING ||
              s.mode == pltok_pkg::MODE_JOINSKIP) && s.len != '0) begin
            if (s.held_bs) begin
               cr = classify(s, pltok_pkg::CH_BSLASH);
               s  = cr.st;
               if (cr.emit) begin
                  res[n] = cr.r;
                  n      = n + 1'b1;
               end
            end
            res[n]      = '0;
            res[n].kind = pltok_pkg::RK_EOL;
            res[n].sep  = s.sep_found;
            n           = n + 1'b1;
         end
         res[n]      = '0;
         res[n].kind = pltok_pkg::RK_EOI;
         n           = n + 1'b1;
         s           = pltok_pkg::clear_state();
      end else begin
         case (s.mode)
            pltok_pkg::MODE_COMMENT: begin
               if (is_eol(byte_i)) begin
                  s = pltok_pkg::clear_state();
               end else begin
                  s.len = s.len + 1'b1;
                  if (s.len >= LIMIT) begin
                     s           = pltok_pkg::clear_state();
                     s.mode      = pltok_pkg::MODE_DROP;
                     res[n]      = '0;
                     res[n].kind = pltok_pkg::RK_LONG;
                     n           = n + 1'b1;
                  end
               end
            end
            pltok_pkg::MODE_BODY: body = 1'b1;
            pltok_pkg::MODE_PENDING, pltok_pkg::MODE_JOINSKIP: begin
               if (s.mode == pltok_pkg::MODE_PENDING) begin
                  // the joining backslash leaves the line
                  if (s.len != '0) s.len = s.len - 1'b1;
                  s.held_bs = 1'b0;
                  s.skip_lf = s.eol_cr;
                  s.eol_cr  = 1'b0;
                  s.mode    = pltok_pkg::MODE_JOINSKIP;
               end
               if (s.skip_lf) begin
                  s.skip_lf = 1'b0;
                  if (byte_i == pltok_pkg::CH_LF) stop = 1'b1;
               end
               if (!stop && !is_blank(byte_i)) begin
                  s.mode = pltok_pkg::MODE_BODY;
                  body   = 1'b1;
               end
            end
            pltok_pkg::MODE_DROP: ;
            default: begin
               s.mode = pltok_pkg::MODE_START;
               if (!is_blank(byte_i) && !is_eol(byte_i)) begin
                  if (byte_i == pltok_pkg::CH_HASH || byte_i == pltok_pkg::CH_BANG) begin
                     s.mode = pltok_pkg::MODE_COMMENT;
                  end else begin
                     s.mode = pltok_pkg::MODE_BODY;
                     app    = 1'b1;
                  end
               end
            end
         endcase

         if (body && is_eol(byte_i)) begin
            // end of a physical line
            if (s.len == '0) begin
               s = pltok_pkg::clear_state();
            end else if (s.held_bs) begin
               s.mode   = pltok_pkg::MODE_PENDING;
               s.eol_cr = (byte_i == pltok_pkg::CH_CR);
            end else begin
               res[n]      = '0;
               res[n].kind = pltok_pkg::RK_EOL;
               res[n].sep  = s.sep_found;
               n           = n + 1'b1;
               s           = pltok_pkg::clear_state();
            end
         end else if (body || app) begin
            if (s.len == '0) begin
               s.phase     = (byte_i == pltok_pkg::CH_LBRACK) ? pltok_pkg::PH_SECTION
                                                              : pltok_pkg::PH_KEY;
               s.key_esc   = 1'b0;
               s.sep_found = 1'b0;
            end
            s.len = s.len + 1'b1;
            if (s.len >= LIMIT) begin
               s           = pltok_pkg::clear_state();
               s.mode      = pltok_pkg::MODE_DROP;
               res[n]      = '0;
               res[n].kind = pltok_pkg::RK_LONG;
               n           = n + 1'b1;
            end else if (byte_i == pltok_pkg::CH_BSLASH && !s.held_bs) begin
               s.held_bs = 1'b1;
            end else begin
               // a held backslash goes out first; a second one pairs with it
               if (s.held_bs) begin
                  s.held_bs = 1'b0;
                  cr        = classify(s, pltok_pkg::CH_BSLASH);
                  s         = cr.st;
                  if (cr.emit) begin
                     res[n] = cr.r;
                     n      = n + 1'b1;
                  end
               end
               cr = classify(s, byte_i);
               s  = cr.st;
               if (cr.emit) begin
                  res[n] = cr.r;
                  n      = n + 1'b1;
               end
            end
         end
      end

      if (n != '0) res[n - 1'b1].last = 1'b1;

      st_o  = s;
      res_o = res;
      cnt_o = n;
   end

endmodule

`default_nettype wire

### rtl/properties_line_tokenizer_top.sv
// Top level of the properties line tokenizer: handshakes, state and result buffer.
`default_nettype none

// Takes a properties-style text file one byte per item (req_tuser = 1 marks end
// of file) and emits the logical-line text byte by byte, each tagged as key,
// value or section-line byte, plus end-of-line, line-too-long and end-of-input
// markers. Comment lines, blank lines and leading blanks are dropped; a
// backslash before CR/LF joins lines. An item is registered on entry, decided
// by one level of logic against the tokenizer state, and its results are
// registered into the result buffer, from which the first result is offered
// on rsp. Rate: one item per cycle while items give at most one result each
// and rsp is not stalled; an item that gives two or three results keeps the
// next item waiting in the input register, since the result buffer drains
// one result per cycle on the rsp side while rsp_tready is high. A line that
// reaches MAX_LINE bytes (comment lines included) raises line-too-long and
// drops the rest of the file.
module properties_line_tokenizer_top #(
   parameter int unsigned MAX_LINE = pltok_pkg::MAX_LINE_DEF
) (
   input  var logic         clock,
   input  var logic         reset,
   input  var logic         req_tvalid,
   output logic             req_tready,
   input  var logic [7:0]   req_tdata,   // [7:0] byte_in
   input  var logic [0:0]   req_tuser,   // [0] kind (1 = end of file)
   output logic             rsp_tvalid,
   input  var logic         rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] character, [8] separator_seen, rest 0
   output logic [3:0]       rsp_tuser,   // [1:0] result_kind, [3:2] role
   output logic             rsp_tlast    // last result of the input item
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic        in_kind_ff, in_kind_in;
   logic [7:0]  in_byte_ff, in_byte_in;

   // tokenizer state
   pltok_pkg::st_type st_ff, st_in, st_next;

   // result buffer: up to three results of one item, head at entry 0
   pltok_pkg::rslt_type [pltok_pkg::RES_MAX-1:0] res_ff, res_in, step_res;
   logic [pltok_pkg::RES_IDX_W-1:0]              cnt_ff, cnt_in, step_cnt;

   logic req_hs, rsp_hs, buf_free, step_go;

   assign req_hs   = req_tvalid && req_tready;
   assign rsp_hs   = rsp_tvalid && rsp_tready;
   // buffer can take a new bundle when empty or its last result leaves now
   assign buf_free = (cnt_ff == '0) || (cnt_ff == 2'd1 && rsp_tready);
   assign step_go  = in_valid_ff && buf_free;
   assign req_tready = !in_valid_ff || step_go;

   pltok_step #(
      .MAX_LINE (MAX_LINE)
   ) u_step (
      .st_i   (st_ff),
      .kind_i (in_kind_ff),
      .byte_i (in_byte_ff),
      .st_o   (st_next),
      .res_o  (step_res),
      .cnt_o  (step_cnt)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_kind_in  = in_kind_ff;
      in_byte_in  = in_byte_ff;
      if (req_hs) begin
         in_valid_in = 1'b1;
         in_kind_in  = req_tuser[0];
         in_byte_in  = req_tdata;
      end else if (step_go) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      st_in  = step_go ? st_next : st_ff;
      res_in = res_ff;
      cnt_in = cnt_ff;
      if (step_go) begin
         res_in = step_res;
         cnt_in = step_cnt;
      end else if (rsp_hs) begin
         res_in[0] = res_ff[1];
         res_in[1] = res_ff[2];
         res_in[2] = '0;
         cnt_in    = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         st_ff       <= pltok_pkg::clear_state();
         cnt_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         st_ff       <= st_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_kind_ff <= in_kind_in;
      in_byte_ff <= in_byte_in;
      res_ff     <= res_in;
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = {7'b0, res_ff[0].sep, res_ff[0].chr};
   assign rsp_tuser  = {res_ff[0].role, res_ff[0].kind};
   assign rsp_tlast  = res_ff[0].last;

   // the last-of-item mark sits only on the final buffered result
   a_last_at_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> cnt_ff == 2'd1)
      else $error("last mark not on final buffered result");

   // end of file puts the tokenizer back to its reset state
   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      step_go && in_kind_ff |=> st_ff.mode == pltok_pkg::MODE_START && st_ff.len == '0
                                && !st_ff.held_bs)
      else $error("state not cleared after end of file");

   // the stored line length never reaches the limit
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff.len < pltok_pkg::LEN_W'(MAX_LINE))
      else $error("line length reached limit");

   // a stalled input item stays in the input register unchanged
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_go |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_kind_ff))
      else $error("stalled input item lost");

endmodule

`default_nettype wire
